[src/elic_pkg.sv]
// ---------------------------------------------------------------------------
// Edge/level interrupt controller package
// Shared constants, codes and transaction types of the interrupt controller.
// ---------------------------------------------------------------------------
`default_nettype none

package elic_pkg;

	localparam int NUM_SOURCES = 32;
	localparam int DATA_W      = 32;
	localparam int S_TDATA_W   = 64;
	localparam int S_TUSER_W   = 4;
	localparam int M_TDATA_W   = 40;

	localparam logic [DATA_W-1:0] SRC_MASK = (NUM_SOURCES >= DATA_W) ? {DATA_W{1'b1}} :
		DATA_W'((64'd1 << NUM_SOURCES) - 64'd1);

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		REG_EVENTS = 2'd0,
		REG_MASK   = 2'd1,
		REG_CLEAR  = 2'd2,
		REG_LEVELS = 2'd3
	} reg_t;

	typedef struct packed {
		op_t               op;
		reg_t              idx;
		logic [DATA_W-1:0] wdata;
		logic [DATA_W-1:0] lines;
	} item_t;

	typedef struct packed {
		logic              irq;
		logic [DATA_W-1:0] read_data;
	} result_t;

endpackage

`default_nettype wire

[src/edge_level_interrupt_controller.sv]
// ---------------------------------------------------------------------------
// Edge/level interrupt controller
// Thirty-two source interrupt controller with edge latching, level sources,
// an enable mask and write-one-to-clear events, driven by a transaction stream.
// ---------------------------------------------------------------------------
// A taken transaction enters the input register, its result the output register.
// Throughput: one transaction per cycle unless the output stalls; the input and
// output registers together let a new transaction enter while a result waits.
// Reset: arst_n clears the events, mask, levels, source type and all valid flags.
`default_nettype none

module edge_level_interrupt_controller (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [elic_pkg::DATA_W-1:0]      cfg_data,
	input  wire logic                             s_tvalid,
	output      logic                             s_tready,
	// Fields from bit 0: write_data[31:0], source_lines[63:32].
	input  wire logic [elic_pkg::S_TDATA_W-1:0]   s_tdata,
	// Fields from bit 0: operation[1:0], reg_index[3:2].
	input  wire logic [elic_pkg::S_TUSER_W-1:0]   s_tuser,
	output      logic                             m_tvalid,
	input  wire logic                             m_tready,
	// Fields from bit 0: read_data[31:0], irq[32], zero padding[39:33].
	output      logic [elic_pkg::M_TDATA_W-1:0]   m_tdata
);

	logic              valid_s1;
	elic_pkg::item_t   item_s1;
	elic_pkg::result_t result;
	logic              out_free;
	logic              advance;

	assign advance = valid_s1 && out_free;

	elic_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	elic_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.advance  (advance),
		.item_s1  (item_s1),
		.result   (result)
	);

	elic_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.result   (result),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

[src/elic_in_reg.sv]
// ---------------------------------------------------------------------------
// Input register
// Captures one accepted transaction and holds it until the core consumes it.
// ---------------------------------------------------------------------------
`default_nettype none

module elic_in_reg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output      logic                             s_tready,
	input  wire logic [elic_pkg::S_TDATA_W-1:0]   s_tdata,
	input  wire logic [elic_pkg::S_TUSER_W-1:0]   s_tuser,
	input  wire logic                             advance,
	output      logic                             valid_s1,
	output      elic_pkg::item_t                  item_s1
);

	logic accept;

	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op    <= elic_pkg::op_t'(s_tuser[1:0]);
			item_s1.idx   <= elic_pkg::reg_t'(s_tuser[3:2]);
			item_s1.wdata <= s_tdata[31:0] & elic_pkg::SRC_MASK;
			item_s1.lines <= s_tdata[63:32] & elic_pkg::SRC_MASK;
		end
	end

endmodule

`default_nettype wire

[src/elic_core.sv]
// ---------------------------------------------------------------------------
// Controller core
// Holds the event, mask, level and type registers and computes one result.
// ---------------------------------------------------------------------------
`default_nettype none

module elic_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [elic_pkg::DATA_W-1:0]   cfg_data,
	input  wire logic                          advance,
	input  wire elic_pkg::item_t               item_s1,
	output      elic_pkg::result_t             result
);

	logic [elic_pkg::DATA_W-1:0] level_type_q;
	logic [elic_pkg::DATA_W-1:0] event_latch_q;
	logic [elic_pkg::DATA_W-1:0] enable_mask_q;
	logic [elic_pkg::DATA_W-1:0] last_lines_q;

	logic [elic_pkg::DATA_W-1:0] event_next;
	logic [elic_pkg::DATA_W-1:0] mask_next;
	logic [elic_pkg::DATA_W-1:0] lines_next;
	logic [elic_pkg::DATA_W-1:0] rdata;

	always_comb begin
		event_next = event_latch_q;
		mask_next  = enable_mask_q;
		lines_next = last_lines_q;
		rdata      = '0;
		case (item_s1.op)
			elic_pkg::OP_TICK: begin
				event_next = event_latch_q | (item_s1.lines & ~last_lines_q & enable_mask_q &
					~level_type_q & elic_pkg::SRC_MASK);
				lines_next = item_s1.lines;
			end
			elic_pkg::OP_READ: begin
				case (item_s1.idx)
					elic_pkg::REG_EVENTS: rdata = event_latch_q;
					elic_pkg::REG_MASK:   rdata = enable_mask_q;
					elic_pkg::REG_LEVELS: rdata = last_lines_q;
					default:              rdata = '0;
				endcase
			end
			elic_pkg::OP_WRITE: begin
				if (item_s1.idx == elic_pkg::REG_MASK) begin
					mask_next = item_s1.wdata;
				end else if (item_s1.idx == elic_pkg::REG_CLEAR) begin
					event_next = event_latch_q & ~item_s1.wdata;
				end
			end
			default: begin
			end
		endcase
		result.read_data = rdata & elic_pkg::SRC_MASK;
		result.irq       = |((event_next | (lines_next & mask_next & level_type_q)) &
			elic_pkg::SRC_MASK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_type_q <= '0;
		end else if (cfg_we) begin
			level_type_q <= cfg_data & elic_pkg::SRC_MASK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_latch_q <= '0;
			enable_mask_q <= '0;
			last_lines_q  <= '0;
		end else if (advance) begin
			event_latch_q <= event_next;
			enable_mask_q <= mask_next;
			last_lines_q  <= lines_next;
		end
	end

endmodule

`default_nettype wire

[src/elic_out_reg.sv]
// ---------------------------------------------------------------------------
// Output register
// Holds one result transaction until the downstream side takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module elic_out_reg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             load,
	input  wire elic_pkg::result_t                result,
	output      logic                             out_free,
	output      logic                             m_tvalid,
	input  wire logic                             m_tready,
	output      logic [elic_pkg::M_TDATA_W-1:0]   m_tdata
);

	logic              out_valid_s2;
	elic_pkg::result_t out_s2;

	assign out_free = !out_valid_s2 || m_tready;
	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {7'd0, out_s2.irq, out_s2.read_data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (out_free) begin
			out_valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_s2 <= result;
		end
	end

endmodule

`default_nettype wire

[src/elic_checker.sv]
// ---------------------------------------------------------------------------
// Interrupt controller port checker
// Concurrent checks on the stream ports of the interrupt controller.
// ---------------------------------------------------------------------------
`default_nettype none

module elic_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_tvalid,
	input wire logic                             s_tready,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [elic_pkg::M_TDATA_W-1:0]   m_tdata
);

	logic in_xfer;

	assign in_xfer = s_tvalid && s_tready;

	// A stalled result transaction keeps its valid and its data.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result transaction changed while stalled");

	// The input side only stalls when a result is waiting and not taken.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a blocked result");

	// Padding bits above irq are always zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:33] == 7'd0)
		else $error("nonzero padding in result");

	// With no input transaction now or in the sample before, and no result shown, none appears.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && !in_xfer && !$past(in_xfer) |=> !m_tvalid)
		else $error("result appeared without an input transaction");

endmodule

bind edge_level_interrupt_controller elic_checker u_elic_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

[dv/tb_edge_level_interrupt_controller.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Edge/level interrupt controller testbench
// Sends ticks, register reads, register writes and reserved operations into the
// controller and checks every response against a cycle-free model of the event,
// mask and level registers. A directed table comes first, then random traffic
// under several source-type settings, with random input gaps and output stalls.
// ---------------------------------------------------------------------------

module tb_edge_level_interrupt_controller;

	import elic_pkg::*;

	localparam op_t OP_UNUSED   = op_t'(2'd3);
	localparam int  STALL_LIMIT = 2000;
	localparam int  DRAIN_CYCLES = 8;
	localparam int  HOLD_CYCLES = 80;
	localparam int  HOLD_AFTER  = 400;
	localparam int  PHASE_ITEMS = 270;
	localparam int  NUM_PHASES  = 6;

	typedef struct packed {
		logic              is_cfg;
		op_t               op;
		reg_t              idx;
		logic [DATA_W-1:0] wdata;
		logic [DATA_W-1:0] lines;
		logic              fixed;
		logic [DATA_W-1:0] exp_data;
		logic              exp_irq;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [DATA_W-1:0]    cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [S_TUSER_W-1:0] s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;

	logic [DATA_W-1:0] ctl_events;
	logic [DATA_W-1:0] ctl_enable;
	logic [DATA_W-1:0] ctl_lines;
	logic [DATA_W-1:0] ctl_level_type;

	result_t pending_responses[$];
	int      error_count;
	int      responses_seen;
	int      irq_high_seen;
	int      tick_count;
	int      read_count;
	int      write_count;
	int      unused_op_count;
	int      type_settings;
	int      stall_cycles;
	bit      calm;
	bit      held_off;

	edge_level_interrupt_controller dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic result_t step_controller(input item_t it);
		result_t           r;
		logic [DATA_W-1:0] data;
		logic [DATA_W-1:0] lines;
		r.read_data = '0;
		data = it.wdata & SRC_MASK;
		lines = it.lines & SRC_MASK;
		case (it.op)
			OP_TICK: begin
				ctl_events |= lines & ~ctl_lines & ctl_enable & ~ctl_level_type & SRC_MASK;
				ctl_lines = lines;
			end
			OP_READ: begin
				case (it.idx)
					REG_EVENTS: r.read_data = ctl_events & SRC_MASK;
					REG_MASK:   r.read_data = ctl_enable & SRC_MASK;
					REG_LEVELS: r.read_data = ctl_lines & SRC_MASK;
					default:    r.read_data = '0;
				endcase
			end
			OP_WRITE: begin
				if (it.idx == REG_MASK) begin
					ctl_enable = data;
				end else if (it.idx == REG_CLEAR) begin
					ctl_events &= ~data;
				end
			end
			default: ;
		endcase
		r.irq = |((ctl_events | (ctl_lines & ctl_enable & ctl_level_type)) & SRC_MASK);
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_item(input item_t it, input bit fixed, input result_t fixed_res);
		result_t r;
		while (!calm && $urandom_range(99) < 23) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {it.lines, it.wdata};
		s_tuser <= {it.idx, it.op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = step_controller(it);
		pending_responses.push_back(fixed ? fixed_res : r);
		case (it.op)
			OP_TICK:  tick_count++;
			OP_READ:  read_count++;
			OP_WRITE: write_count++;
			default:  unused_op_count++;
		endcase
		@(negedge clk);
	endtask

	task automatic set_source_type(input logic [DATA_W-1:0] value);
		s_tvalid <= 1'b0;
		while (pending_responses.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		ctl_level_type = value & SRC_MASK;
		type_settings++;
	endtask

	function automatic item_t random_item();
		item_t   it;
		int      pick;
		int      sub;
		pick = $urandom_range(99);
		sub = $urandom_range(9);
		it.op = OP_UNUSED;
		it.idx = reg_t'($urandom_range(3));
		it.wdata = $urandom;
		it.lines = $urandom;
		if (pick < 40) begin
			it.op = OP_TICK;
			if (sub == 0) begin
				it.lines = '0;
			end else if (sub == 1) begin
				it.lines = '1;
			end else if (sub < 6) begin
				it.lines = ctl_lines ^ (32'd1 << $urandom_range(31)) ^ ($urandom & $urandom & $urandom);
			end
		end else if (pick < 65) begin
			it.op = OP_READ;
		end else if (pick < 95) begin
			it.op = OP_WRITE;
			if (sub < 4) begin
				it.idx = REG_MASK;
				if ($urandom_range(3) == 0) begin
					it.wdata = '1;
				end else if ($urandom_range(3) != 0) begin
					it.wdata = $urandom | $urandom;
				end
			end else if (sub < 8) begin
				it.idx = REG_CLEAR;
				if ($urandom_range(4) == 0) begin
					it.wdata = '1;
				end else if ($urandom_range(1) == 0) begin
					it.wdata = $urandom & $urandom;
				end
			end
		end
		return it;
	endfunction

	// Responses are checked in order of acceptance.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[DATA_W:0]);
			responses_seen++;
			if (got.irq) begin
				irq_high_seen++;
			end
			if (pending_responses.size() == 0) begin
				report_mismatch($sformatf("unexpected response data=%08h irq=%0b",
					got.read_data, got.irq));
			end else begin
				want = pending_responses.pop_front();
				if (got.read_data !== want.read_data) begin
					report_mismatch($sformatf("read_data got %08h expected %08h",
						got.read_data, want.read_data));
				end
				if (got.irq !== want.irq) begin
					report_mismatch($sformatf("irq got %0b expected %0b", got.irq, want.irq));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("Some tests failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		m_tready = 1'b0;
		held_off = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && responses_seen >= HOLD_AFTER) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 23);
			end
		end
	end

	initial begin
		stim_row_t directed_rows [26];
		stim_row_t row;
		logic [DATA_W-1:0] type_values [NUM_PHASES];

		directed_rows = '{
			'{1'b0, OP_READ,    REG_EVENTS, 32'h0,        32'h0,        1'b1, 32'h0,        1'b0},
			'{1'b0, OP_READ,    REG_MASK,   32'h0,        32'h0,        1'b1, 32'h0,        1'b0},
			'{1'b0, OP_READ,    REG_CLEAR,  32'h0,        32'h0,        1'b1, 32'h0,        1'b0},
			'{1'b0, OP_READ,    REG_LEVELS, 32'h0,        32'h0,        1'b1, 32'h0,        1'b0},
			'{1'b0, OP_UNUSED,  REG_LEVELS, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h0,        1'b0},
			'{1'b0, OP_TICK,    REG_EVENTS, 32'h0,        32'hFFFFFFFF, 1'b0, 32'h0,        1'b0},
			'{1'b0, OP_READ,    REG_LEVELS, 32'h0,        32'h0,        1'b1, 32'hFFFFFFFF, 1'b0},
			'{1'b0, OP_WRITE,   REG_MASK,   32'hFFFFFFFF, 32'h0,        1'b0, 32'h0,        1'b0},
			'{1'b0, OP_TICK,    REG_EVENTS, 32'h0,        32'h0,        1'b0, 32'h0,        1'b0},
			'{1'b0, OP_TICK,    REG_EVENTS, 32'h0,        32'hFFFFFFFF, 1'b0, 32'h0,        1'b0},
			'{1'b0, OP_READ,    REG_EVENTS, 32'h0,        32'h0,        1'b1, 32'hFFFFFFFF, 1'b1},
			'{1'b0, OP_READ,    REG_CLEAR,  32'h0,        32'h0,        1'b1, 32'h0,        1'b1},
			'{1'b0, OP_WRITE,   REG_EVENTS, 32'h0,        32'h0,        1'b0, 32'h0,        1'b0},
			'{1'b0, OP_WRITE,   REG_LEVELS, 32'h0,        32'h0,        1'b0, 32'h0,        1'b0},
			'{1'b0, OP_WRITE,   REG_CLEAR,  32'h0000FFFF, 32'h0,        1'b0, 32'h0,        1'b0},
			'{1'b0, OP_WRITE,   REG_MASK,   32'h0,        32'h0,        1'b0, 32'h0,        1'b0},
			'{1'b0, OP_READ,    REG_EVENTS, 32'h0,        32'h0,        1'b0, 32'h0,        1'b0},
			'{1'b0, OP_TICK,    REG_EVENTS, 32'h0,        32'h0,        1'b0, 32'h0,        1'b0},
			'{1'b0, OP_TICK,    REG_EVENTS, 32'h0,        32'h55555555, 1'b0, 32'h0,        1'b0},
			'{1'b0, OP_WRITE,   REG_CLEAR,  32'hFFFFFFFF, 32'h0,        1'b0, 32'h0,        1'b0},
			'{1'b1, OP_TICK,    REG_EVENTS, 32'hFFFF0000, 32'h0,        1'b0, 32'h0,        1'b0},
			'{1'b0, OP_WRITE,   REG_MASK,   32'hFFFFFFFF, 32'h0,        1'b0, 32'h0,        1'b0},
			'{1'b0, OP_TICK,    REG_EVENTS, 32'h0,        32'h00010001, 1'b0, 32'h0,        1'b0},
			'{1'b0, OP_READ,    REG_EVENTS, 32'h0,        32'h0,        1'b0, 32'h0,        1'b0},
			'{1'b0, OP_WRITE,   REG_CLEAR,  32'hFFFFFFFF, 32'h0,        1'b0, 32'h0,        1'b0},
			'{1'b0, OP_TICK,    REG_EVENTS, 32'h0,        32'h0,        1'b0, 32'h0,        1'b0}
		};
		type_values = '{32'hFFFFFFFF, 32'h00000000, $urandom, 32'h5A5AA5A5, $urandom,
			32'h0000FFFF};

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		calm = 1'b0;
		error_count = 0;
		responses_seen = 0;
		irq_high_seen = 0;
		tick_count = 0;
		read_count = 0;
		write_count = 0;
		unused_op_count = 0;
		type_settings = 0;
		ctl_events = '0;
		ctl_enable = '0;
		ctl_lines = '0;
		ctl_level_type = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.is_cfg) begin
				set_source_type(row.wdata);
			end else begin
				send_item('{row.op, row.idx, row.wdata, row.lines}, row.fixed,
					'{row.exp_irq, row.exp_data});
			end
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			set_source_type(type_values[p]);
			calm = (p == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_item(random_item(), 1'b0, '0);
			end
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		while (pending_responses.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Ran %0d ticks, %0d reads, %0d writes and %0d reserved operations",
			tick_count, read_count, write_count, unused_op_count);
		$display("over %0d source-type settings; %0d responses checked, irq high in %0d",
			type_settings, responses_seen, irq_high_seen);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[filelist.f]
src/elic_pkg.sv
src/elic_in_reg.sv
src/elic_core.sv
src/elic_out_reg.sv
src/edge_level_interrupt_controller.sv
src/elic_checker.sv
dv/tb_edge_level_interrupt_controller.sv
